### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared macros for the concurrent checks of the motion shaper.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, held off while reset is asserted.
`define PMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, including during reset.
`define PMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/pms_pkg.sv
// ----------------------------------------------------------------------------
// pms_pkg
// Types and fixed constants shared by the motion shaper and its arithmetic unit.
// ----------------------------------------------------------------------------
package pms_pkg;

  // Operation codes of the shared arithmetic unit.
  typedef logic [1:0] pms_op_t;
  localparam pms_op_t OP_DIV  = 2'd0;
  localparam pms_op_t OP_SQRT = 2'd1;
  localparam pms_op_t OP_MUL  = 2'd2;

  // Request from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic    start;
    pms_op_t op;
  } pms_req_t;

  // Motion modes; the spare code is pointer mode as well.
  localparam logic [1:0] MODE_POINTER = 2'd0;
  localparam logic [1:0] MODE_SCROLL  = 2'd1;
  localparam logic [1:0] MODE_VOLUME  = 2'd2;
  localparam logic [1:0] MODE_SPARE   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DIV_H    = 2'd0;
  localparam logic [1:0] CFG_DIV_V    = 2'd1;
  localparam logic [1:0] CFG_DEADZONE = 2'd2;
  localparam logic [1:0] CFG_ZONE     = 2'd3;

  // Fixed divisor for volume motion and the output limit.
  localparam logic [7:0] VOL_DIVISOR = 8'd18;
  localparam logic [6:0] OUT_LIMIT   = 7'd127;

endpackage

### hw/rtl/pms_unit.sv
// ----------------------------------------------------------------------------
// pms_unit
// Shared arithmetic unit: restoring divider and square root one digit per
// cycle, and a multiplier whose registered product is scaled down by the
// fraction width.
// ----------------------------------------------------------------------------
module pms_unit import pms_pkg::*; #(
  parameter int FRAC_BITS = 16,
  localparam int Q  = FRAC_BITS + 16,
  localparam int AW = (FRAC_BITS + 2 > 16) ? FRAC_BITS + 2 : 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  pms_req_t      req,
  input  logic [AW-1:0] opa,
  input  logic [AW-1:0] opb,
  output logic          done,
  output logic [Q-1:0]  result
);

  localparam int RW = 19;
  localparam int CW = $clog2(Q + 1);

  logic          busy_r;
  logic          done_r;
  pms_op_t       op_r;
  logic [CW-1:0] cnt_r;
  logic [15:0]   num_r;
  logic [15:0]   den_r;
  logic [RW-1:0] rem_r;
  logic [Q-1:0]  q_r;

  logic [RW-1:0]   pre;
  logic [RW-1:0]   subv;
  logic [RW:0]     diff;
  logic            ge;
  logic [2*AW-1:0] prod;
  logic [2*AW-1:0] prod_sh;

  // One digit step: bring down the next dividend bit or radicand bit pair,
  // then try to subtract the divisor or the trial root.
  always_comb begin
    if (op_r == OP_SQRT) begin
      pre  = {rem_r[RW-3:0], num_r[15:14]};
      subv = RW'({q_r[15:0], 2'b01});
    end else begin
      pre  = {rem_r[RW-2:0], num_r[15]};
      subv = RW'(den_r);
    end
    diff = {1'b0, pre} - {1'b0, subv};
    ge   = ~diff[RW];
  end

  // Multiplier with the fixed point scaling applied.
  assign prod    = opa * opb;
  assign prod_sh = prod >> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        op_r  <= req.op;
        num_r <= opa[15:0];
        den_r <= opb[15:0];
        rem_r <= '0;
        if (req.op == OP_MUL) begin
          q_r    <= prod_sh[Q-1:0];
          done_r <= 1'b1;
        end else begin
          q_r    <= '0;
          busy_r <= 1'b1;
          cnt_r  <= (req.op == OP_SQRT) ? CW'(16) : CW'(Q);
        end
      end else if (busy_r) begin
        rem_r <= ge ? diff[RW-1:0] : pre;
        q_r   <= {q_r[Q-2:0], ge};
        num_r <= (op_r == OP_SQRT) ? {num_r[13:0], 2'b00} : {num_r[14:0], 1'b0};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = q_r;

endmodule

### hw/rtl/pointer_motion_shaper_core.sv
// ----------------------------------------------------------------------------
// pointer_motion_shaper_core
// Shapes one trackpad motion delta per request into pointer motion, wheel
// counts or volume pulses, using one shared divide/root/multiply unit.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake            | Payload
//  in_      | input     | in_valid / in_stall  | delta_x, delta_y, mode, accel_on
//  out_     | output    | out_valid / out_stall| out_x, out_y, wheel_h/v, vol_up/down
//  cfg_     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A volume request is handled without the shared unit; scroll and pointer
// requests wait on that unit, whose divider retires one quotient bit per cycle.
// in_stall is high from acceptance until the result is loaded into the output
// register. A stalled output holds the next result back in its final state.
// Reset clears the accumulators and restores the register defaults.
// ----------------------------------------------------------------------------
module pointer_motion_shaper_core import pms_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [7:0] in_delta_x,
  input  logic signed [7:0] in_delta_y,
  input  logic [1:0]        in_mode,
  input  logic              in_accel_on,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] out_out_x,
  output logic signed [7:0] out_out_y,
  output logic signed [7:0] out_wheel_h,
  output logic signed [7:0] out_wheel_v,
  output logic              out_vol_up,
  output logic              out_vol_down,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

`include "assert_macros.svh"

  localparam int Q     = FRAC_BITS + 16;
  localparam int AW    = (FRAC_BITS + 2 > 16) ? FRAC_BITS + 2 : 16;
  localparam int ACC_W = FRAC_BITS + 9;
  localparam int VQ_W  = FRAC_BITS + 8;
  localparam logic signed [ACC_W-1:0] ONE_ACC  = ACC_W'(1) << FRAC_BITS;
  localparam logic [ACC_W-1:0]        FRAC_MSK = (ACC_W'(1) << FRAC_BITS) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] JIT_STEP = ACC_W'((64'd1 << FRAC_BITS) / 3);
  localparam logic [FRAC_BITS:0]      ONE_F    = {1'b1, {FRAC_BITS{1'b0}}};
  localparam longint unsigned         VOL_ONE  = 64'd1 << FRAC_BITS;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_VOL     = 4'd1;
  localparam logic [3:0] ST_SCR_H   = 4'd2;
  localparam logic [3:0] ST_SCR_V   = 4'd3;
  localparam logic [3:0] ST_SCR_FIN = 4'd4;
  localparam logic [3:0] ST_PT_PREP = 4'd5;
  localparam logic [3:0] ST_PT_SQ   = 4'd6;
  localparam logic [3:0] ST_PT_SQRT = 4'd7;
  localparam logic [3:0] ST_PT_DIV  = 4'd8;
  localparam logic [3:0] ST_PT_T2   = 4'd9;
  localparam logic [3:0] ST_PT_S    = 4'd10;
  localparam logic [3:0] ST_PT_X    = 4'd11;
  localparam logic [3:0] ST_PT_Y    = 4'd12;
  localparam logic [3:0] ST_DONE    = 4'd13;

  // Configuration registers.
  logic [7:0]  div_h_r;
  logic [7:0]  div_v_r;
  logic [15:0] dz_r;
  logic [15:0] zone_r;

  // Accumulators.
  logic signed [ACC_W-1:0] vol_acc_r;
  logic signed [ACC_W-1:0] sh_acc_r;
  logic signed [ACC_W-1:0] sv_acc_r;
  logic signed [ACC_W-1:0] jx_acc_r;
  logic signed [ACC_W-1:0] jy_acc_r;

  // Sequencer and working registers.
  logic [3:0]         state_r;
  logic               issued_r;
  logic signed [7:0]  dx_r;
  logic signed [7:0]  dy_r;
  logic [1:0]         mode_r;
  logic               accel_r;
  logic signed [7:0]  px_r;
  logic signed [7:0]  py_r;
  logic [15:0]        sq_r;
  logic [15:0]        mag_r;
  logic [FRAC_BITS:0] t_r;
  logic [FRAC_BITS:0] t2_r;
  logic [FRAC_BITS:0] f_r;

  // Result being built, and the output register.
  logic signed [7:0] res_x_r, res_y_r, res_wh_r, res_wv_r;
  logic              res_up_r, res_dn_r;
  logic              out_valid_r;
  logic signed [7:0] ox_r, oy_r, owh_r, owv_r;
  logic              oup_r, odn_r;

  // Unit connection.
  pms_req_t      u_req;
  logic [AW-1:0] u_a;
  logic [AW-1:0] u_b;
  logic          u_done;
  logic [Q-1:0]  u_result;

  logic                    op_state;
  logic                    neg;
  logic signed [ACC_W-1:0] qmag;
  logic signed [ACC_W-1:0] qadd;
  logic signed [ACC_W-1:0] sum_a;
  logic signed [ACC_W-1:0] sum_b;
  logic [6:0]              cl_mul;
  logic signed [15:0]      sqx;
  logic signed [15:0]      sqy;
  logic                    tiny;
  logic [FRAC_BITS:0]      t_sat;

  // Magnitude of the integer part of an accumulator, truncated toward zero.
  function automatic logic [7:0] int_mag(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] a;
    a = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    return a[FRAC_BITS+7:FRAC_BITS];
  endfunction

  // Fraction left in an accumulator once its integer part is taken out.
  function automatic logic signed [ACC_W-1:0] frac_keep(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] a;
    logic [ACC_W-1:0] m;
    a = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    m = a & FRAC_MSK;
    return v[ACC_W-1] ? -$signed(m) : $signed(m);
  endfunction

  // Signed clamped count from an accumulator.
  function automatic logic signed [7:0] count_of(input logic signed [ACC_W-1:0] v);
    logic [7:0] m;
    logic [7:0] c;
    m = int_mag(v);
    c = (m > 8'(OUT_LIMIT)) ? 8'(OUT_LIMIT) : m;
    return v[ACC_W-1] ? -$signed(c) : $signed(c);
  endfunction

  // Absolute value of a signed delta.
  function automatic logic [7:0] abs8(input logic signed [7:0] v);
    return v[7] ? 8'(-v) : 8'(v);
  endfunction

  // Volume step: a magnitude times one, divided by the volume divisor. The
  // whole part comes from three compare and subtract steps, the fraction of
  // the remainder from a small constant table.
  function automatic logic [VQ_W-1:0] vol_quot(input logic [7:0] a);
    logic [7:0]      r;
    logic [2:0]      h;
    logic [VQ_W-1:0] f;
    r = a;
    h = '0;
    if (r >= (VOL_DIVISOR << 2)) begin
      r    = r - (VOL_DIVISOR << 2);
      h[2] = 1'b1;
    end
    if (r >= (VOL_DIVISOR << 1)) begin
      r    = r - (VOL_DIVISOR << 1);
      h[1] = 1'b1;
    end
    if (r >= VOL_DIVISOR) begin
      r    = r - VOL_DIVISOR;
      h[0] = 1'b1;
    end
    case (r)
      8'd1:    f = VQ_W'((VOL_ONE * 1) / VOL_DIVISOR);
      8'd2:    f = VQ_W'((VOL_ONE * 2) / VOL_DIVISOR);
      8'd3:    f = VQ_W'((VOL_ONE * 3) / VOL_DIVISOR);
      8'd4:    f = VQ_W'((VOL_ONE * 4) / VOL_DIVISOR);
      8'd5:    f = VQ_W'((VOL_ONE * 5) / VOL_DIVISOR);
      8'd6:    f = VQ_W'((VOL_ONE * 6) / VOL_DIVISOR);
      8'd7:    f = VQ_W'((VOL_ONE * 7) / VOL_DIVISOR);
      8'd8:    f = VQ_W'((VOL_ONE * 8) / VOL_DIVISOR);
      8'd9:    f = VQ_W'((VOL_ONE * 9) / VOL_DIVISOR);
      8'd10:   f = VQ_W'((VOL_ONE * 10) / VOL_DIVISOR);
      8'd11:   f = VQ_W'((VOL_ONE * 11) / VOL_DIVISOR);
      8'd12:   f = VQ_W'((VOL_ONE * 12) / VOL_DIVISOR);
      8'd13:   f = VQ_W'((VOL_ONE * 13) / VOL_DIVISOR);
      8'd14:   f = VQ_W'((VOL_ONE * 14) / VOL_DIVISOR);
      8'd15:   f = VQ_W'((VOL_ONE * 15) / VOL_DIVISOR);
      8'd16:   f = VQ_W'((VOL_ONE * 16) / VOL_DIVISOR);
      8'd17:   f = VQ_W'((VOL_ONE * 17) / VOL_DIVISOR);
      default: f = '0;
    endcase
    return f + VQ_W'({h, {FRAC_BITS{1'b0}}});
  endfunction

  // Operand selection for the shared unit.
  always_comb begin
    op_state = 1'b1;
    u_req.op = OP_DIV;
    u_a      = '0;
    u_b      = '0;
    case (state_r)
      ST_SCR_H: begin
        u_a = AW'(abs8(dx_r));
        u_b = (div_h_r == 8'd0) ? AW'(1) : AW'(div_h_r);
      end
      ST_SCR_V: begin
        u_a = AW'(abs8(dy_r));
        u_b = (div_v_r == 8'd0) ? AW'(1) : AW'(div_v_r);
      end
      ST_PT_SQRT: begin
        u_req.op = OP_SQRT;
        u_a      = AW'(sq_r);
      end
      ST_PT_DIV: begin
        u_a = AW'(mag_r - dz_r);
        u_b = AW'(zone_r - dz_r);
      end
      ST_PT_T2: begin
        u_req.op = OP_MUL;
        u_a      = AW'(t_r);
        u_b      = AW'(t_r);
      end
      ST_PT_S: begin
        u_req.op = OP_MUL;
        u_a      = AW'(t2_r);
        u_b      = (AW'(3) << FRAC_BITS) - AW'({t_r, 1'b0});
      end
      ST_PT_X: begin
        u_req.op = OP_MUL;
        u_a      = AW'(abs8(px_r));
        u_b      = AW'(f_r);
      end
      ST_PT_Y: begin
        u_req.op = OP_MUL;
        u_a      = AW'(abs8(py_r));
        u_b      = AW'(f_r);
      end
      default: op_state = 1'b0;
    endcase
    u_req.start = op_state && !issued_r;
  end

  pms_unit #(.FRAC_BITS(FRAC_BITS)) u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (u_req),
    .opa    (u_a),
    .opb    (u_b),
    .done   (u_done),
    .result (u_result)
  );

  // Signed quotient to add into an accumulator, and the clamped product.
  always_comb begin
    neg    = (state_r == ST_SCR_H) ? dx_r[7] : dy_r[7];
    qmag   = (state_r == ST_VOL) ? $signed({1'b0, vol_quot(abs8(dy_r))}) :
                                   $signed({1'b0, u_result[FRAC_BITS+7:0]});
    qadd   = neg ? -qmag : qmag;
    sum_a  = ((state_r == ST_SCR_H) ? sh_acc_r :
              (state_r == ST_SCR_V) ? sv_acc_r : vol_acc_r) + qadd;
    cl_mul = (|u_result[Q-1:7]) ? OUT_LIMIT : u_result[6:0];
    t_sat  = (u_result > Q'(ONE_F)) ? ONE_F : u_result[FRAC_BITS:0];
    sqx    = px_r * px_r;
    sqy    = py_r * py_r;
  end

  // Jitter filter for moves of at most one count along a single axis.
  always_comb begin
    tiny  = (dx_r inside {8'h00, 8'h01, 8'hFF}) && (dy_r inside {8'h00, 8'h01, 8'hFF})
            && !(dx_r != 8'sd0 && dy_r != 8'sd0);
    sum_b = jx_acc_r + ((dx_r == 8'sd1) ? JIT_STEP :
                        (dx_r == -8'sd1) ? -JIT_STEP : ACC_W'(0));
  end

  logic signed [ACC_W-1:0] jy_sum;
  assign jy_sum = jy_acc_r + ((dy_r == 8'sd1) ? JIT_STEP :
                              (dy_r == -8'sd1) ? -JIT_STEP : ACC_W'(0));

  // Configuration writes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_h_r <= 8'd50;
      div_v_r <= 8'd30;
      dz_r    <= 16'd64;
      zone_r  <= 16'd51200;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DIV_H:    div_h_r <= cfg_data[7:0];
        CFG_DIV_V:    div_v_r <= cfg_data[7:0];
        CFG_DEADZONE: dz_r    <= cfg_data;
        CFG_ZONE:     zone_r  <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      vol_acc_r   <= '0;
      sh_acc_r    <= '0;
      sv_acc_r    <= '0;
      jx_acc_r    <= '0;
      jy_acc_r    <= '0;
    end else begin
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      if (u_req.start) begin
        issued_r <= 1'b1;
      end
      if (u_done) begin
        issued_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            dx_r     <= in_delta_x;
            dy_r     <= in_delta_y;
            mode_r   <= in_mode;
            accel_r  <= in_accel_on;
            res_x_r  <= '0;
            res_y_r  <= '0;
            res_wh_r <= '0;
            res_wv_r <= '0;
            res_up_r <= 1'b0;
            res_dn_r <= 1'b0;
            if (in_mode == MODE_VOLUME) begin
              state_r <= ST_VOL;
            end else if (in_mode == MODE_SCROLL) begin
              state_r <= ST_SCR_H;
            end else begin
              state_r <= ST_PT_PREP;
            end
          end
        end
        ST_VOL: begin
          if (sum_a >= ONE_ACC) begin
            res_dn_r  <= 1'b1;
            vol_acc_r <= '0;
          end else if (sum_a <= -ONE_ACC) begin
            res_up_r  <= 1'b1;
            vol_acc_r <= '0;
          end else begin
            vol_acc_r <= sum_a;
          end
          state_r <= ST_DONE;
        end
        ST_SCR_H: begin
          if (u_done) begin
            sh_acc_r <= sum_a;
            state_r  <= ST_SCR_V;
          end
        end
        ST_SCR_V: begin
          if (u_done) begin
            sv_acc_r <= sum_a;
            state_r  <= ST_SCR_FIN;
          end
        end
        ST_SCR_FIN: begin
          // Wheel counts leave, fractions stay; vertical is reported negated.
          res_wh_r <= count_of(sh_acc_r);
          res_wv_r <= -count_of(sv_acc_r);
          sh_acc_r <= frac_keep(sh_acc_r);
          sv_acc_r <= frac_keep(sv_acc_r);
          state_r  <= ST_DONE;
        end
        ST_PT_PREP: begin
          if (tiny) begin
            jx_acc_r <= frac_keep(sum_b);
            jy_acc_r <= frac_keep(jy_sum);
            px_r     <= sum_b[ACC_W-1] ? -$signed(int_mag(sum_b)) : $signed(int_mag(sum_b));
            py_r     <= jy_sum[ACC_W-1] ? -$signed(int_mag(jy_sum)) : $signed(int_mag(jy_sum));
          end else begin
            jx_acc_r <= '0;
            jy_acc_r <= '0;
            px_r     <= dx_r;
            py_r     <= dy_r;
          end
          state_r <= ST_PT_SQ;
        end
        ST_PT_SQ: begin
          sq_r    <= $unsigned(sqx) + $unsigned(sqy);
          state_r <= ST_PT_SQRT;
        end
        ST_PT_SQRT: begin
          if (u_done) begin
            mag_r <= u_result[15:0];
            if (u_result[15:0] < dz_r) begin
              f_r     <= '0;
              state_r <= ST_PT_X;
            end else if (!(accel_r && u_result[15:0] < zone_r)) begin
              f_r     <= ONE_F;
              state_r <= ST_PT_X;
            end else begin
              state_r <= ST_PT_DIV;
            end
          end
        end
        ST_PT_DIV: begin
          if (u_done) begin
            t_r     <= t_sat;
            state_r <= ST_PT_T2;
          end
        end
        ST_PT_T2: begin
          if (u_done) begin
            t2_r    <= u_result[FRAC_BITS:0];
            state_r <= ST_PT_S;
          end
        end
        ST_PT_S: begin
          if (u_done) begin
            f_r     <= u_result[FRAC_BITS:0];
            state_r <= ST_PT_X;
          end
        end
        ST_PT_X: begin
          if (u_done) begin
            res_x_r <= px_r[7] ? -$signed({1'b0, cl_mul}) : $signed({1'b0, cl_mul});
            state_r <= ST_PT_Y;
          end
        end
        ST_PT_Y: begin
          if (u_done) begin
            res_y_r <= py_r[7] ? -$signed({1'b0, cl_mul}) : $signed({1'b0, cl_mul});
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Hand the result to the output register once it is free.
          if (!out_valid_r || !out_stall) begin
            ox_r        <= res_x_r;
            oy_r        <= res_y_r;
            owh_r       <= res_wh_r;
            owv_r       <= res_wv_r;
            oup_r       <= res_up_r;
            odn_r       <= res_dn_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall     = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_out_x    = ox_r;
  assign out_out_y    = oy_r;
  assign out_wheel_h  = owh_r;
  assign out_wheel_v  = owv_r;
  assign out_vol_up   = oup_r;
  assign out_vol_down = odn_r;

  // Checks.
  `PMS_ASSERT(a_accept_busy, in_valid && !in_stall |=> in_stall, "accepted request did not hold off input")
  `PMS_ASSERT(a_vol_onehot, out_valid |-> $onehot0({out_vol_up, out_vol_down}), "both volume pulses set")
  `PMS_ASSERT(a_done_issued, u_done |-> issued_r, "unit finished without a request")
  `PMS_ASSERT_ALWAYS(a_mode_x, !rst_n |=> !out_valid, "output valid out of reset")

endmodule
